/* hw/rtl/kcl_pkg.sv */
// Shared types and constants for the keypad code lock controller.
`default_nettype none

package kcl_pkg;

   localparam logic [3:0] KEY_STAR  = 4'd10;
   localparam logic [3:0] KEY_POUND = 4'd11;

   localparam logic CMD_PRESS   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_VERIFY = 2'd1,
      MODE_SET    = 2'd2
   } kcl_mode_type;

   typedef struct packed {
      logic       command;
      logic [3:0] key;
   } kcl_req_type;

   typedef struct packed {
      logic       accepted;
      logic       unlock;
      logic       code_stored;
      logic [1:0] mode_now;
      logic [1:0] digits_entered;
   } kcl_rsp_type;

   typedef struct packed {
      logic         code_valid;
      kcl_mode_type lock_mode;
      logic         key_held;
   } kcl_ctl_type;

endpackage

`default_nettype wire

/* hw/rtl/kcl_eval.sv */
// Next-state and result logic for one key event of the code lock.
`default_nettype none

module kcl_eval
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 4,
   parameter int CW          = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
   input  kcl_req_type req_word,
   input  kcl_ctl_type ctl,
   input  logic [CW-1:0] count,
   input  logic [3:0] entry [CODE_LENGTH],
   input  logic [3:0] stored [CODE_LENGTH],
   output kcl_ctl_type ctl_next,
   output logic [CW-1:0] count_next,
   output logic [3:0] entry_next [CODE_LENGTH],
   output logic store_en,
   output kcl_rsp_type rsp_word
);

   localparam int DW = (CW > 2) ? CW : 2;

   logic is_star;
   logic is_match;
   logic unlock;
   logic accepted;
   logic [DW-1:0] count_ext;

   always_comb begin
      is_star  = 1'b1;
      is_match = 1'b1;
      accepted = 1'b0;
      unlock   = 1'b0;
      store_en = 1'b0;
      ctl_next   = ctl;
      count_next = count;
      entry_next = entry;
      if (req_word.command == CMD_RELEASE) begin
         ctl_next.key_held = 1'b0;
      end else if (!ctl.key_held) begin
         ctl_next.key_held = 1'b1;
         accepted = 1'b1;
         if (req_word.key == KEY_POUND) begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               entry_next[i] = 4'd0;
            end
            count_next = '0;
         end else begin
            for (int i = 0; i < CODE_LENGTH; i++) begin
               if (CW'(i) == count) begin
                  entry_next[i] = req_word.key;
               end
            end
            for (int i = 0; i < CODE_LENGTH; i++) begin
               if (entry_next[i] != KEY_STAR) begin
                  is_star = 1'b0;
               end
               if (entry_next[i] != stored[i]) begin
                  is_match = 1'b0;
               end
            end
            if (count != CW'(CODE_LENGTH - 1)) begin
               count_next = count + CW'(1);
            end else begin
               count_next = '0;
               case (ctl.lock_mode)
                  MODE_NORMAL: begin
                     if (!ctl.code_valid) begin
                        store_en = 1'b1;
                        ctl_next.code_valid = 1'b1;
                     end
                     if (is_star) begin
                        ctl_next.lock_mode = MODE_VERIFY;
                     end else if (is_match || !ctl.code_valid) begin
                        unlock = 1'b1;
                     end
                  end
                  MODE_VERIFY: begin
                     ctl_next.lock_mode = is_match ? MODE_SET : MODE_NORMAL;
                  end
                  MODE_SET: begin
                     if (!is_star) begin
                        store_en = 1'b1;
                        ctl_next.code_valid = 1'b1;
                        ctl_next.lock_mode  = MODE_NORMAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   assign count_ext = DW'(count_next);

   assign rsp_word.accepted       = accepted;
   assign rsp_word.unlock         = unlock;
   assign rsp_word.code_stored    = store_en;
   assign rsp_word.mode_now       = ctl_next.lock_mode;
   assign rsp_word.digits_entered = count_ext[1:0];

endmodule

`default_nettype wire

/* hw/rtl/keypad_code_lock_controller.sv */
// The lock state updates in a single pass between the input and result registers.
// Throughput: one key event word per cycle unless the result side stalls.
// Stalls on the result side back up through the input register to req_stall.
// Reset clears the lock state, the entry buffer and both pipeline valid flags;
// the stored code is undefined until the first code is written.
`default_nettype none

module keypad_code_lock_controller
   import kcl_pkg::*;
#(
   parameter int CODE_LENGTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  kcl_req_type req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output kcl_rsp_type rsp_word
);

   localparam int CW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   logic          in_valid_ff, in_valid_in;
   kcl_req_type   in_word_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   kcl_rsp_type   rsp_word_ff, rsp_word_in;
   kcl_ctl_type   ctl_ff, ctl_in;
   logic [CW-1:0] count_ff, count_in;
   logic [3:0]    entry_ff [CODE_LENGTH];
   logic [3:0]    entry_in [CODE_LENGTH];
   logic [3:0]    stored_ff [CODE_LENGTH];
   logic          store_en;
   logic          advance;
   logic          req_take;
   logic          step;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   kcl_eval #(
      .CODE_LENGTH(CODE_LENGTH),
      .CW(CW)
   ) u_eval (
      .req_word(in_word_ff),
      .ctl(ctl_ff),
      .count(count_ff),
      .entry(entry_ff),
      .stored(stored_ff),
      .ctl_next(ctl_in),
      .count_next(count_in),
      .entry_next(entry_in),
      .store_en(store_en),
      .rsp_word(rsp_word_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctl_ff       <= '{code_valid: 1'b0, lock_mode: MODE_NORMAL, key_held: 1'b0};
         count_ff     <= '0;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            entry_ff[i] <= 4'd0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            ctl_ff   <= ctl_in;
            count_ff <= count_in;
            entry_ff <= entry_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (step) begin
         rsp_word_ff <= rsp_word_in;
      end
      if (step && store_en) begin
         stored_ff <= entry_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

/* hw/rtl/kcl_checker.sv */
// Port-level assertions for the keypad code lock controller, bound to the top level.
`default_nettype none

module kcl_checker
   import kcl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire kcl_req_type req_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire kcl_rsp_type rsp_word
);

   // A stalled result word must be held unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // Unlocking or storing a code can only follow an accepted press.
   a_action_needs_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.unlock || rsp_word.code_stored) |-> rsp_word.accepted)
      else $error("action reported without an accepted press");

   // An unlock is only given in normal mode, and never together with a new code in set mode.
   a_unlock_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.unlock |-> rsp_word.mode_now == MODE_NORMAL)
      else $error("unlock outside normal mode");

   // A code is written only on a completed entry, which never leaves the lock in set mode.
   a_store_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.code_stored |->
         rsp_word.mode_now != MODE_SET && rsp_word.digits_entered == 2'd0)
      else $error("code stored with inconsistent mode or count");

   // The unused mode code never appears.
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.mode_now != 2'd3)
      else $error("invalid mode reported");

endmodule

bind keypad_code_lock_controller kcl_checker u_kcl_checker (.*);

`default_nettype wire

/* test/tb_keypad_code_lock_controller.sv */
// Self-checking testbench for the keypad code lock controller, with its own prediction model.
`timescale 1ns / 1ps

module tb_keypad_code_lock_controller;
   import kcl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   kcl_req_type req_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   kcl_rsp_type rsp_word;

   keypad_code_lock_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   kcl_req_type key_events[$];
   bit          drain_marks[$];
   kcl_rsp_type expected_results[$];

   logic [3:0][3:0] lock_code = '0;
   logic            lock_code_set = 1'b0;
   logic [3:0][3:0] lock_entry = '0;
   int              lock_count = 0;
   kcl_mode_type    lock_mode = MODE_NORMAL;
   logic            lock_held = 1'b0;

   logic [3:0][3:0] plan_code;
   int total_words = 1;
   int words_sent = 0;
   int send_idle_pct;
   int recv_stall_pct;
   int errors = 0;
   int cycle_count = 0;
   kcl_rsp_type got_word;

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic predict_key_event(input kcl_req_type w);
      kcl_rsp_type r;
      logic all_star;
      r = '0;
      if (w.command == CMD_RELEASE) begin
         lock_held = 1'b0;
      end else if (!lock_held) begin
         lock_held = 1'b1;
         r.accepted = 1'b1;
         if (w.key == KEY_POUND) begin
            lock_entry = '0;
            lock_count = 0;
         end else begin
            if (lock_count < 4) lock_entry[lock_count] = w.key;
            lock_count++;
            if (lock_count >= 4) begin
               lock_count = 0;
               all_star = (lock_entry == {4{KEY_STAR}});
               case (lock_mode)
                  MODE_NORMAL: begin
                     if (!lock_code_set) begin
                        lock_code = lock_entry;
                        lock_code_set = 1'b1;
                        r.code_stored = 1'b1;
                     end
                     if (all_star) lock_mode = MODE_VERIFY;
                     else if (lock_entry == lock_code) r.unlock = 1'b1;
                  end
                  MODE_VERIFY: begin
                     lock_mode = (lock_entry == lock_code) ? MODE_SET : MODE_NORMAL;
                  end
                  MODE_SET: begin
                     if (!all_star) begin
                        lock_code = lock_entry;
                        r.code_stored = 1'b1;
                        lock_mode = MODE_NORMAL;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      r.mode_now = lock_mode;
      r.digits_entered = lock_count[1:0];
      expected_results.push_back(r);
   endtask

   task automatic queue_event(input logic cmd, input logic [3:0] key, input bit drain = 1'b0);
      kcl_req_type w;
      w.command = cmd;
      w.key = key;
      key_events.push_back(w);
      drain_marks.push_back(drain);
   endtask

   task automatic queue_tap(input logic [3:0] key);
      queue_event(CMD_PRESS, key);
      queue_event(CMD_RELEASE, 4'($urandom_range(15)));
   endtask

   task automatic queue_entry(input logic [3:0][3:0] code);
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(19) == 0) begin
            queue_event(CMD_PRESS, code[i]);
            queue_event(CMD_PRESS, 4'($urandom_range(15)));
            queue_event(CMD_RELEASE, 4'($urandom_range(15)));
         end else begin
            queue_tap(code[i]);
         end
      end
   endtask

   function automatic logic [3:0][3:0] random_code();
      logic [3:0][3:0] c;
      for (int i = 0; i < 4; i++) begin
         if ($urandom_range(4) == 0) begin
            c[i] = 4'($urandom_range(15));
            if (c[i] == KEY_POUND) c[i] = 4'd15;
         end else begin
            c[i] = 4'($urandom_range(9));
         end
      end
      if (c == {4{KEY_STAR}}) c[0] = 4'd0;
      return c;
   endfunction

   task automatic queue_sequence();
      int pick;
      logic [3:0][3:0] fresh;
      pick = $urandom_range(99);
      queue_event(CMD_RELEASE, 4'($urandom_range(15)), $urandom_range(39) == 0);
      queue_tap(KEY_POUND);
      if (pick < 35) begin
         queue_entry(plan_code);
      end else if (pick < 55) begin
         queue_entry(random_code());
      end else if (pick < 72) begin
         fresh = random_code();
         queue_entry({4{KEY_STAR}});
         queue_entry(plan_code);
         if ($urandom_range(3) == 0) queue_entry({4{KEY_STAR}});
         queue_entry(fresh);
         plan_code = fresh;
      end else if (pick < 80) begin
         queue_entry({4{KEY_STAR}});
         queue_entry(random_code());
      end else if (pick < 88) begin
         fresh = random_code();
         for (int i = 0; i < $urandom_range(3); i++) queue_tap(fresh[i]);
         queue_tap(KEY_POUND);
         queue_entry(plan_code);
      end else begin
         for (int i = 0; i <= $urandom_range(2); i++)
            queue_event(1'($urandom_range(1)), 4'($urandom_range(15)));
      end
   endtask

   always_comb begin
      case (words_sent * 3 / total_words)
         0: begin
            send_idle_pct = 25;
            recv_stall_pct = 56;
         end
         1: begin
            send_idle_pct = 56;
            recv_stall_pct = 25;
         end
         default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
      endcase
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_key_event(req_word);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || !req_stall) begin
            if (key_events.size() > 0 && drain_marks[0] && expected_results.size() == 0)
               drain_marks[0] = 1'b0;
            if (key_events.size() == 0 || drain_marks[0] ||
                $urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_word <= key_events.pop_front();
               void'(drain_marks.pop_front());
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_word = rsp_word;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: result word with none expected: %p", $time, got_word);
            end else if (got_word !== expected_results[0]) begin
               errors++;
               $display("%0t: expected %p, got %p", $time, expected_results[0], got_word);
               void'(expected_results.pop_front());
            end else begin
               void'(expected_results.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      queue_event(CMD_RELEASE, 4'd15);
      queue_event(CMD_PRESS, 4'd12);
      queue_event(CMD_PRESS, 4'd3);
      queue_event(CMD_RELEASE, 4'd0);
      queue_tap(KEY_POUND);
      for (int i = 0; i < 4; i++) queue_tap(4'd0);
      for (int i = 0; i < 4; i++) queue_tap(KEY_STAR);
      plan_code = '0;
      queue_event(CMD_RELEASE, 4'd0, 1'b1);
      while (key_events.size() < 1900) queue_sequence();
      total_words = key_events.size();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (key_events.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_results.size() > 0) errors++;
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
